### rtl/spo2r_pkg.sv
// ----------------------------------------------------------------------------
// spo2r_pkg
// Shared types and constants of the SpO2 ratio-of-ratios estimator.
// ----------------------------------------------------------------------------
package spo2r_pkg;

   localparam int LEVEL_W     = 24;
   localparam int RATIO_W     = 20;
   localparam int SPO2_W      = 15;
   localparam int QUAL_W      = 16;
   localparam int CONF_W      = 16;
   localparam int VERSION_W   = 16;
   localparam int COEF_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_A      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_B      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_C      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_MIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_MAX   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_IS_CAL      = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALLOW_UNCAL = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_VERSION     = 3'd7;

   localparam logic signed [COEF_W-1:0] COEF_A_RST = 32'sh0000_0000;
   localparam logic signed [COEF_W-1:0] COEF_B_RST = 32'shFFE7_0000;
   localparam logic signed [COEF_W-1:0] COEF_C_RST = 32'sh006E_0000;
   localparam logic [RATIO_W-1:0]       RATIO_MIN_RST = 20'd13107;
   localparam logic [RATIO_W-1:0]       RATIO_MAX_RST = 20'd131072;

   // quality and correlation gates
   localparam logic [16:0] CORR_MIN = 17'd19661;

   // ac_ir / dc_ir floor of 1e-8
   localparam int              TINY_K_W = 27;
   localparam logic [TINY_K_W-1:0] TINY_K = 27'd100000000;

   // calibration sum in Q.32
   localparam int SUM_W = 60;
   localparam logic signed [SUM_W-1:0] SUM_LO  = 60'sd300647710720;
   localparam logic signed [SUM_W-1:0] SUM_HI  = 60'sd431644213248;
   localparam logic signed [SUM_W-1:0] SUM_TOP = 60'sd429496729600;

   // confidence
   localparam int              MARGIN_W   = 17;
   localparam int              WEIGHT_W   = 23;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BASE = 23'd4259840;
   localparam logic [WEIGHT_W-1:0] WEIGHT_SLOPE = 23'd35;
   localparam logic [6:0]      GAIN_CAL   = 7'd100;
   localparam logic [6:0]      GAIN_UNCAL = 7'd60;
   localparam int              SCALED_W   = 30;
   localparam int              RECIP_W    = 31;
   localparam logic [RECIP_W-1:0] RECIP_10K = 31'd1759218605;
   localparam int              RECIP_SHIFT = 44;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_OK_UNCAL    = 3'd1,
      ST_NO_SIGNAL   = 3'd2,
      ST_LOW_QUALITY = 3'd3,
      ST_INTERNAL    = 3'd4,
      ST_RANGE       = 3'd5,
      ST_NOT_READY   = 3'd6
   } status_type;

   typedef struct packed {
      logic                      pulse_detected;
      logic [QUAL_W-1:0]         quality_level;
      logic signed [15:0]        correlation;
      logic [LEVEL_W-1:0]        dc_red_level;
      logic [LEVEL_W-1:0]        dc_ir_level;
      logic [LEVEL_W-1:0]        ac_red_level;
      logic [LEVEL_W-1:0]        ac_ir_level;
   } req_type;

   typedef struct packed {
      logic                      estimate_valid;
      logic [2:0]                status;
      logic [SPO2_W-1:0]         spo2_value;
      logic [RATIO_W-1:0]        ratio_value;
      logic [CONF_W-1:0]         confidence;
      logic                      calibrated_echo;
      logic [VERSION_W-1:0]      version_echo;
   } rsp_type;

   typedef struct packed {
      logic                      fail;
      status_type                status;
      logic [QUAL_W-1:0]         qual;
   } early_type;

   typedef struct packed {
      logic                      fail;
      logic                      est;
      status_type                status;
      logic [RATIO_W-1:0]        ratio;
      logic [SPO2_W-1:0]         spo2;
      logic [QUAL_W-1:0]         qual;
      logic                      msat;
   } post_type;

endpackage

### rtl/spo2r_div.sv
// ----------------------------------------------------------------------------
// spo2r_div
// Pipelined restoring divider, one quotient bit per stage. Needs rem < den.
// ----------------------------------------------------------------------------
module spo2r_div #(
   parameter int DEN_W = 52,
   parameter int QUO_W = 20,
   parameter int SB_W  = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  logic [DEN_W-1:0] in_rem,
   input  logic [DEN_W-1:0] in_den,
   input  logic [SB_W-1:0]  in_sb,
   output logic             out_valid,
   output logic [QUO_W-1:0] out_quo,
   output logic [SB_W-1:0]  out_sb
);

   logic             vld_ff [QUO_W];
   logic [DEN_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic [SB_W-1:0]  sb_ff  [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_step
      logic             prev_vld;
      logic [DEN_W-1:0] prev_rem;
      logic [DEN_W-1:0] prev_den;
      logic [QUO_W-1:0] prev_quo;
      logic [SB_W-1:0]  prev_sb;
      logic [DEN_W:0]   dbl;
      logic [DEN_W:0]   diff;
      logic             take;
      logic [DEN_W-1:0] rem_in;
      logic [QUO_W-1:0] quo_in;

      if (k == 0) begin : g_first
         assign prev_vld = in_valid;
         assign prev_rem = in_rem;
         assign prev_den = in_den;
         assign prev_quo = '0;
         assign prev_sb  = in_sb;
      end else begin : g_next
         assign prev_vld = vld_ff[k-1];
         assign prev_rem = rem_ff[k-1];
         assign prev_den = den_ff[k-1];
         assign prev_quo = quo_ff[k-1];
         assign prev_sb  = sb_ff[k-1];
      end

      assign dbl    = {prev_rem, 1'b0};
      assign diff   = dbl - {1'b0, prev_den};
      assign take   = dbl >= {1'b0, prev_den};
      assign rem_in = take ? diff[DEN_W-1:0] : dbl[DEN_W-1:0];
      assign quo_in = {prev_quo[QUO_W-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= prev_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            den_ff[k] <= prev_den;
            quo_ff[k] <= quo_in;
            sb_ff[k]  <= prev_sb;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_sb    = sb_ff[QUO_W-1];

endmodule

### rtl/spo2r_front.sv
// ----------------------------------------------------------------------------
// spo2r_front
// Input gating, level products, floor and ratio overflow checks (two stages).
// ----------------------------------------------------------------------------
module spo2r_front #(
   parameter int LW = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  spo2r_pkg::req_type     in_data,
   output logic                   out_valid,
   output logic [2*LW+3:0]        out_rem,
   output logic [2*LW+3:0]        out_den,
   output spo2r_pkg::early_type   out_early
);

   localparam int TINY_W = LW + spo2r_pkg::TINY_K_W;

   logic [LW-1:0]          dcr, dci, acr, aci;
   logic [16:0]            cabs;
   spo2r_pkg::early_type   early_in;
   logic [2*LW-1:0]        num_in, den_in;
   logic [TINY_W-1:0]      tiny_in;

   logic                   s1_vld_ff;
   spo2r_pkg::early_type   s1_early_ff;
   logic [2*LW-1:0]        s1_num_ff, s1_den_ff;
   logic [TINY_W-1:0]      s1_tiny_ff;
   logic [LW-1:0]          s1_dci_ff;

   logic                   ovf, tiny;
   spo2r_pkg::early_type   early2_in;

   logic                   s2_vld_ff;
   spo2r_pkg::early_type   s2_early_ff;
   logic [2*LW+3:0]        s2_rem_ff, s2_den_ff;

   assign dcr = in_data.dc_red_level[LW-1:0];
   assign dci = in_data.dc_ir_level[LW-1:0];
   assign acr = in_data.ac_red_level[LW-1:0];
   assign aci = in_data.ac_ir_level[LW-1:0];

   assign cabs = in_data.correlation[15] ?
                 (17'h10000 - {1'b0, in_data.correlation}) : {1'b0, in_data.correlation};

   always_comb begin
      early_in.fail   = 1'b1;
      early_in.status = spo2r_pkg::ST_OK;
      early_in.qual   = in_data.quality_level;
      if (!in_data.pulse_detected) begin
         early_in.status = spo2r_pkg::ST_NO_SIGNAL;
      end else if (!in_data.quality_level[15] || cabs < spo2r_pkg::CORR_MIN) begin
         early_in.status = spo2r_pkg::ST_LOW_QUALITY;
      end else if (dcr == '0 || dci == '0 || acr == '0 || aci == '0) begin
         early_in.status = spo2r_pkg::ST_NO_SIGNAL;
      end else begin
         early_in.fail = 1'b0;
      end
   end

   assign num_in  = (2*LW)'(acr) * (2*LW)'(dci);
   assign den_in  = (2*LW)'(dcr) * (2*LW)'(aci);
   assign tiny_in = TINY_W'(aci) * TINY_W'(spo2r_pkg::TINY_K);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_early_ff <= early_in;
         s1_num_ff   <= num_in;
         s1_den_ff   <= den_in;
         s1_tiny_ff  <= tiny_in;
         s1_dci_ff   <= dci;
      end
   end

   assign ovf  = {4'b0, s1_num_ff} >= {s1_den_ff, 4'b0};
   assign tiny = s1_tiny_ff <= TINY_W'(s1_dci_ff);

   always_comb begin
      early2_in = s1_early_ff;
      if (!s1_early_ff.fail && (tiny || ovf)) begin
         early2_in.fail   = 1'b1;
         early2_in.status = spo2r_pkg::ST_INTERNAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_early_ff <= early2_in;
         s2_rem_ff   <= {4'b0, s1_num_ff};
         s2_den_ff   <= {s1_den_ff, 4'b0};
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_rem   = s2_rem_ff;
   assign out_den   = s2_den_ff;
   assign out_early = s2_early_ff;

endmodule

### rtl/spo2r_cal.sv
// ----------------------------------------------------------------------------
// spo2r_cal
// Range check, quadratic calibration and margin operands (three stages).
// ----------------------------------------------------------------------------
module spo2r_cal (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      adv,
   input  logic                                      in_valid,
   input  logic [spo2r_pkg::RATIO_W-1:0]             in_ratio,
   input  spo2r_pkg::early_type                      in_early,
   input  logic signed [spo2r_pkg::COEF_W-1:0]       coef_a,
   input  logic signed [spo2r_pkg::COEF_W-1:0]       coef_b,
   input  logic signed [spo2r_pkg::COEF_W-1:0]       coef_c,
   input  logic [spo2r_pkg::RATIO_W-1:0]             ratio_min,
   input  logic [spo2r_pkg::RATIO_W-1:0]             ratio_max,
   input  logic                                      is_cal,
   input  logic                                      allow_uncal,
   output logic                                      out_valid,
   output logic [spo2r_pkg::RATIO_W:0]               out_rem,
   output logic [spo2r_pkg::RATIO_W:0]               out_den,
   output spo2r_pkg::post_type                       out_post
);

   localparam int RW  = spo2r_pkg::RATIO_W;
   localparam int SW  = spo2r_pkg::SUM_W;

   // stage C
   logic [2*RW-1:0]        rr_in;
   logic signed [52:0]     br_in;
   logic [RW:0]            twice, rsum, d_in;
   logic [RW-1:0]          span_in;
   logic                   c_vld_ff;
   spo2r_pkg::early_type   c_early_ff;
   logic [RW-1:0]          c_r_ff;
   logic [2*RW-1:0]        c_rr_ff;
   logic signed [52:0]     c_br_ff;
   logic                   c_range_ff, c_nrdy_ff, c_msat_ff;
   logic [RW:0]            c_d_ff;
   logic [RW-1:0]          c_span_ff;

   // stage D
   logic [23:0]            r2;
   logic signed [56:0]     ar2_in;
   logic                   d_vld_ff;
   spo2r_pkg::early_type   d_early_ff;
   logic [RW-1:0]          d_r_ff;
   logic signed [56:0]     d_ar2_ff;
   logic signed [52:0]     d_br_ff;
   logic                   d_range_ff, d_nrdy_ff, d_msat_ff;
   logic [RW:0]            d_d_ff;
   logic [RW-1:0]          d_span_ff;

   // stage E
   logic signed [SW-1:0]   sum;
   logic signed [SW-1:0]   clip;
   spo2r_pkg::post_type    post_in;
   logic                   e_vld_ff;
   spo2r_pkg::post_type    e_post_ff;
   logic [RW:0]            e_d_ff;
   logic [RW-1:0]          e_span_ff;

   assign rr_in   = (2*RW)'(in_ratio) * (2*RW)'(in_ratio);
   assign br_in   = 53'(coef_b) * 53'($signed({1'b0, in_ratio}));
   assign twice   = {in_ratio, 1'b0};
   assign rsum    = (RW+1)'(ratio_min) + (RW+1)'(ratio_max);
   assign d_in    = (twice >= rsum) ? (twice - rsum) : (rsum - twice);
   assign span_in = ratio_max - ratio_min;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
         d_vld_ff <= 1'b0;
         e_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= in_valid;
         d_vld_ff <= c_vld_ff;
         e_vld_ff <= d_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c_early_ff <= in_early;
         c_r_ff     <= in_ratio;
         c_rr_ff    <= rr_in;
         c_br_ff    <= br_in;
         c_range_ff <= (in_ratio < ratio_min) || (in_ratio > ratio_max);
         c_nrdy_ff  <= !is_cal && !allow_uncal;
         c_msat_ff  <= d_in >= {1'b0, span_in};
         c_d_ff     <= d_in;
         c_span_ff  <= span_in;
      end
   end

   assign r2     = c_rr_ff[2*RW-1:16];
   assign ar2_in = 57'(coef_a) * 57'($signed({1'b0, r2}));

   always_ff @(posedge clock) begin
      if (adv) begin
         d_early_ff <= c_early_ff;
         d_r_ff     <= c_r_ff;
         d_ar2_ff   <= ar2_in;
         d_br_ff    <= c_br_ff;
         d_range_ff <= c_range_ff;
         d_nrdy_ff  <= c_nrdy_ff;
         d_msat_ff  <= c_msat_ff;
         d_d_ff     <= c_d_ff;
         d_span_ff  <= c_span_ff;
      end
   end

   assign sum  = SW'(d_ar2_ff) + SW'(d_br_ff) + {{(SW-48){coef_c[31]}}, coef_c, 16'b0};
   assign clip = (sum > spo2r_pkg::SUM_TOP) ? spo2r_pkg::SUM_TOP : sum;

   always_comb begin
      post_in.fail   = d_early_ff.fail;
      post_in.est    = 1'b0;
      post_in.status = d_early_ff.status;
      post_in.ratio  = d_r_ff;
      post_in.spo2   = clip[38:24];
      post_in.qual   = d_early_ff.qual;
      post_in.msat   = d_msat_ff;
      if (d_early_ff.fail) begin
         post_in.status = d_early_ff.status;
      end else if (d_range_ff) begin
         post_in.status = spo2r_pkg::ST_RANGE;
      end else if (d_nrdy_ff) begin
         post_in.status = spo2r_pkg::ST_NOT_READY;
      end else if (sum < spo2r_pkg::SUM_LO || sum > spo2r_pkg::SUM_HI) begin
         post_in.status = spo2r_pkg::ST_RANGE;
      end else begin
         post_in.est    = 1'b1;
         post_in.status = is_cal ? spo2r_pkg::ST_OK : spo2r_pkg::ST_OK_UNCAL;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_post_ff <= post_in;
         e_d_ff    <= d_d_ff;
         e_span_ff <= d_span_ff;
      end
   end

   assign out_valid = e_vld_ff;
   assign out_rem   = e_d_ff;
   assign out_den   = {1'b0, e_span_ff};
   assign out_post  = e_post_ff;

endmodule

### rtl/spo2r_conf.sv
// ----------------------------------------------------------------------------
// spo2r_conf
// Confidence scaling and the result register (four stages).
// ----------------------------------------------------------------------------
module spo2r_conf (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               adv,
   input  logic                               in_valid,
   input  logic [15:0]                        in_quo,
   input  spo2r_pkg::post_type                in_post,
   input  logic                               is_cal,
   input  logic [spo2r_pkg::VERSION_W-1:0]    version,
   output logic                               rsp_valid,
   output spo2r_pkg::rsp_type                 rsp_data
);

   localparam int WW = spo2r_pkg::WEIGHT_W;
   localparam int YW = spo2r_pkg::SCALED_W;
   localparam int PW = YW + spo2r_pkg::RECIP_W;

   logic [spo2r_pkg::MARGIN_W-1:0] margin;
   logic [WW-1:0]          w_in, qk_in;
   logic                   f1_vld_ff, f2_vld_ff, f3_vld_ff;
   spo2r_pkg::post_type    f1_post_ff, f2_post_ff, f3_post_ff;
   logic [WW-1:0]          f1_w_ff, f1_qk_ff;
   logic [2*WW-1:0]        prod2;
   logic [YW-1:0]          f2_y_ff;
   logic [PW-1:0]          f3_p_ff;
   spo2r_pkg::rsp_type     rsp_in;
   logic                   rsp_valid_ff;
   spo2r_pkg::rsp_type     rsp_data_ff;

   assign margin = in_post.msat ? '0 : (17'h10000 - {1'b0, in_quo});
   assign w_in   = spo2r_pkg::WEIGHT_BASE + WW'(margin) * spo2r_pkg::WEIGHT_SLOPE;
   assign qk_in  = WW'(in_post.qual) *
                   WW'(is_cal ? spo2r_pkg::GAIN_CAL : spo2r_pkg::GAIN_UNCAL);
   assign prod2  = (2*WW)'(f1_qk_ff) * (2*WW)'(f1_w_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff    <= 1'b0;
         f2_vld_ff    <= 1'b0;
         f3_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff    <= in_valid;
         f2_vld_ff    <= f1_vld_ff;
         f3_vld_ff    <= f2_vld_ff;
         rsp_valid_ff <= f3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_post_ff <= in_post;
         f1_w_ff    <= w_in;
         f1_qk_ff   <= qk_in;
         f2_post_ff <= f1_post_ff;
         f2_y_ff    <= prod2[YW+15:16];
         f3_post_ff <= f2_post_ff;
         f3_p_ff    <= PW'(f2_y_ff) * PW'(spo2r_pkg::RECIP_10K);
         rsp_data_ff <= rsp_in;
      end
   end

   always_comb begin
      rsp_in = '0;
      rsp_in.status = f3_post_ff.status;
      if (!f3_post_ff.fail) begin
         rsp_in.ratio_value     = f3_post_ff.ratio;
         rsp_in.calibrated_echo = is_cal;
         rsp_in.version_echo    = version;
      end
      if (f3_post_ff.est) begin
         rsp_in.estimate_valid = 1'b1;
         rsp_in.spo2_value     = f3_post_ff.spo2;
         rsp_in.confidence     = f3_p_ff[spo2r_pkg::RECIP_SHIFT+15:spo2r_pkg::RECIP_SHIFT];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/spo2_ratio_estimator.sv
// ----------------------------------------------------------------------------
// spo2_ratio_estimator
// Throughput: one transaction per cycle; a stalled result holds the pipeline.
// Pipeline: 2 front stages, 20-stage ratio divider, 3 calibration stages,
// 16-stage margin divider, 3 confidence stages and the result register.
// Reset (synchronous): clears all valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module spo2_ratio_estimator #(
   parameter int LEVEL_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  spo2r_pkg::req_type                     req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output spo2r_pkg::rsp_type                     rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [spo2r_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [spo2r_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int LW    = (LEVEL_BITS < spo2r_pkg::LEVEL_W) ? LEVEL_BITS : spo2r_pkg::LEVEL_W;
   localparam int DW    = 2 * LW + 4;
   localparam int RW    = spo2r_pkg::RATIO_W;
   localparam int E_W   = $bits(spo2r_pkg::early_type);
   localparam int P_W   = $bits(spo2r_pkg::post_type);

   logic signed [spo2r_pkg::COEF_W-1:0] coef_a_ff, coef_b_ff, coef_c_ff;
   logic [RW-1:0]                       ratio_min_ff, ratio_max_ff;
   logic                                is_cal_ff, allow_uncal_ff;
   logic [spo2r_pkg::VERSION_W-1:0]     version_ff;

   logic                   adv;
   logic                   fr_valid;
   logic [DW-1:0]          fr_rem, fr_den;
   spo2r_pkg::early_type   fr_early;
   logic                   rd_valid;
   logic [RW-1:0]          rd_quo;
   logic [E_W-1:0]         rd_sb;
   logic                   cal_valid;
   logic [RW:0]            cal_rem, cal_den;
   spo2r_pkg::post_type    cal_post;
   logic                   md_valid;
   logic [15:0]            md_quo;
   logic [P_W-1:0]         md_sb;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff      <= spo2r_pkg::COEF_A_RST;
         coef_b_ff      <= spo2r_pkg::COEF_B_RST;
         coef_c_ff      <= spo2r_pkg::COEF_C_RST;
         ratio_min_ff   <= spo2r_pkg::RATIO_MIN_RST;
         ratio_max_ff   <= spo2r_pkg::RATIO_MAX_RST;
         is_cal_ff      <= 1'b0;
         allow_uncal_ff <= 1'b1;
         version_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            spo2r_pkg::CSR_COEF_A:      coef_a_ff      <= $signed(csr_data);
            spo2r_pkg::CSR_COEF_B:      coef_b_ff      <= $signed(csr_data);
            spo2r_pkg::CSR_COEF_C:      coef_c_ff      <= $signed(csr_data);
            spo2r_pkg::CSR_RATIO_MIN:   ratio_min_ff   <= csr_data[RW-1:0];
            spo2r_pkg::CSR_RATIO_MAX:   ratio_max_ff   <= csr_data[RW-1:0];
            spo2r_pkg::CSR_IS_CAL:      is_cal_ff      <= csr_data[0];
            spo2r_pkg::CSR_ALLOW_UNCAL: allow_uncal_ff <= csr_data[0];
            spo2r_pkg::CSR_VERSION:     version_ff     <= csr_data[spo2r_pkg::VERSION_W-1:0];
            default: ;
         endcase
      end
   end

   spo2r_front #(.LW(LW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (fr_valid),
      .out_rem   (fr_rem),
      .out_den   (fr_den),
      .out_early (fr_early)
   );

   spo2r_div #(.DEN_W(DW), .QUO_W(RW), .SB_W(E_W)) u_ratio_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (fr_valid),
      .in_rem    (fr_rem),
      .in_den    (fr_den),
      .in_sb     (fr_early),
      .out_valid (rd_valid),
      .out_quo   (rd_quo),
      .out_sb    (rd_sb)
   );

   spo2r_cal u_cal (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (rd_valid),
      .in_ratio    (rd_quo),
      .in_early    (spo2r_pkg::early_type'(rd_sb)),
      .coef_a      (coef_a_ff),
      .coef_b      (coef_b_ff),
      .coef_c      (coef_c_ff),
      .ratio_min   (ratio_min_ff),
      .ratio_max   (ratio_max_ff),
      .is_cal      (is_cal_ff),
      .allow_uncal (allow_uncal_ff),
      .out_valid   (cal_valid),
      .out_rem     (cal_rem),
      .out_den     (cal_den),
      .out_post    (cal_post)
   );

   spo2r_div #(.DEN_W(RW + 1), .QUO_W(16), .SB_W(P_W)) u_margin_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (cal_valid),
      .in_rem    (cal_rem),
      .in_den    (cal_den),
      .in_sb     (cal_post),
      .out_valid (md_valid),
      .out_quo   (md_quo),
      .out_sb    (md_sb)
   );

   spo2r_conf u_conf (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (md_valid),
      .in_quo    (md_quo),
      .in_post   (spo2r_pkg::post_type'(md_sb)),
      .is_cal    (is_cal_ff),
      .version   (version_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/spo2r_checker.sv
// ----------------------------------------------------------------------------
// spo2r_checker
// Port-level checks on the result channel of the estimator.
// ----------------------------------------------------------------------------
module spo2r_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input spo2r_pkg::rsp_type  rsp_data
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transaction changed");

   a_est_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.estimate_valid |->
      (rsp_data.status == spo2r_pkg::ST_OK || rsp_data.status == spo2r_pkg::ST_OK_UNCAL))
      else $error("estimate with failing status");

   a_no_est_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.estimate_valid |->
      rsp_data.spo2_value == '0 && rsp_data.confidence == '0)
      else $error("spo2 or confidence without estimate");

   a_early_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == spo2r_pkg::ST_NO_SIGNAL ||
                    rsp_data.status == spo2r_pkg::ST_LOW_QUALITY ||
                    rsp_data.status == spo2r_pkg::ST_INTERNAL) |->
      rsp_data.ratio_value == '0 && !rsp_data.calibrated_echo &&
      rsp_data.version_echo == '0 && !rsp_data.estimate_valid)
      else $error("early failure with nonzero fields");

endmodule

bind spo2_ratio_estimator spo2r_checker u_spo2r_checker (.*);

### tb/tb_spo2_ratio_estimator.sv
// ----------------------------------------------------------------------------
// tb_spo2_ratio_estimator
// Self-checking testbench for the SpO2 ratio-of-ratios estimator: a directed
// table of windows, then random windows under several calibration settings,
// each result compared field by field to its table row or in-bench estimate.
// ----------------------------------------------------------------------------
module tb_spo2_ratio_estimator;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 45;
   localparam int LIMIT   = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   spo2r_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   spo2r_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [spo2r_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [spo2r_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   spo2_ratio_estimator DUT (.*);

   always #5 clock = ~clock;

   // calibration copy
   logic signed [31:0] cal_a, cal_b, cal_c;
   logic [19:0] lim_min, lim_max;
   logic cal_flag, allow_flag;
   logic [15:0] cal_ver;

   spo2r_pkg::rsp_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 13, recv_idle = 60;

   typedef struct {
      spo2r_pkg::req_type w;
      bit                 has_rsp;
      spo2r_pkg::rsp_type r;
   } row_type;

   function automatic spo2r_pkg::rsp_type estimate(spo2r_pkg::req_type w);
      spo2r_pkg::rsp_type o;
      logic [16:0] cabs;
      logic [63:0] num, den, q, rem, r, span, d, t, m, conf, twice, sum;
      logic signed [63:0] r2, s, spo2;
      o = '0;
      if (!w.pulse_detected) begin
         o.status = spo2r_pkg::ST_NO_SIGNAL; return o;
      end
      cabs = w.correlation[15] ? 17'h10000 - {1'b0, w.correlation} : {1'b0, w.correlation};
      if (w.quality_level < 16'd32768 || cabs < 17'd19661) begin
         o.status = spo2r_pkg::ST_LOW_QUALITY; return o;
      end
      if (w.dc_red_level == 0 || w.dc_ir_level == 0 || w.ac_red_level == 0 ||
          w.ac_ir_level == 0) begin
         o.status = spo2r_pkg::ST_NO_SIGNAL; return o;
      end
      if (64'(w.ac_ir_level) * 64'd100000000 <= 64'(w.dc_ir_level)) begin
         o.status = spo2r_pkg::ST_INTERNAL; return o;
      end
      num = 64'(w.ac_red_level) * 64'(w.dc_ir_level);
      den = 64'(w.dc_red_level) * 64'(w.ac_ir_level);
      q = num / den;
      if (q >= 16) begin
         o.status = spo2r_pkg::ST_INTERNAL; return o;
      end
      rem = num % den;
      r = q;
      for (int i = 0; i < 16; i++) begin
         if (rem >= den - rem) begin
            rem = rem - (den - rem); r = (r << 1) | 1;
         end else begin
            rem = rem << 1; r = r << 1;
         end
      end
      o.ratio_value = r[19:0];
      o.calibrated_echo = cal_flag;
      o.version_echo = cal_ver;
      if (r < lim_min || r > lim_max) begin
         o.status = spo2r_pkg::ST_RANGE; return o;
      end
      if (!cal_flag && !allow_flag) begin
         o.status = spo2r_pkg::ST_NOT_READY; return o;
      end
      r2 = signed'((r * r) >> 16);
      s = 64'(cal_a) * r2 + 64'(cal_b) * signed'(r) + 64'(cal_c) * 64'sd65536;
      if (s < (64'sd70 <<< 32) || s > (64'sd201 <<< 31)) begin
         o.status = spo2r_pkg::ST_RANGE; return o;
      end
      if (s > (64'sd100 <<< 32)) s = 64'sd100 <<< 32;
      spo2 = s >>> 24;
      span = 64'(lim_max) - 64'(lim_min);
      if (span > 0) begin
         twice = 2 * r; sum = 64'(lim_min) + 64'(lim_max);
         d = twice >= sum ? twice - sum : sum - twice;
         t = (d << 16) / span;
         m = t >= 65536 ? 0 : 65536 - t;
      end else begin
         m = 0;
      end
      conf = 64'(w.quality_level) * (65 * 65536 + 35 * m) * (cal_flag ? 100 : 60)
             / (64'd65536 * 64'd10000);
      o.estimate_valid = 1'b1;
      o.status = cal_flag ? spo2r_pkg::ST_OK : spo2r_pkg::ST_OK_UNCAL;
      o.spo2_value = spo2[14:0];
      o.confidence = conf[15:0];
      return o;
   endfunction

   task automatic csr_write(logic [spo2r_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1; csr_index <= idx; csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         spo2r_pkg::CSR_COEF_A:      cal_a = val;
         spo2r_pkg::CSR_COEF_B:      cal_b = val;
         spo2r_pkg::CSR_COEF_C:      cal_c = val;
         spo2r_pkg::CSR_RATIO_MIN:   lim_min = val[19:0];
         spo2r_pkg::CSR_RATIO_MAX:   lim_max = val[19:0];
         spo2r_pkg::CSR_IS_CAL:      cal_flag = val[0];
         spo2r_pkg::CSR_ALLOW_UNCAL: allow_flag = val[0];
         default:                    cal_ver = val[15:0];
      endcase
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic send(spo2r_pkg::req_type w, bit has_rsp = 0,
                       spo2r_pkg::rsp_type r = '0);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0; @(posedge clock);
      end
      req_valid <= 1'b1; req_data <= w;
      expected_q.push_back(has_rsp ? r : estimate(w));
      do @(posedge clock); while (req_stall);
   endtask

   function automatic spo2r_pkg::req_type rand_window();
      spo2r_pkg::req_type w;
      logic [23:0] base;
      w.pulse_detected = $urandom_range(99) < 95;
      w.quality_level = $urandom_range(99) < 85 ? 16'($urandom_range(65535, 32768))
                                                : 16'($urandom);
      w.correlation = $urandom_range(99) < 85 ?
                      ($urandom_range(1) ? 16'($urandom_range(32767, 19661))
                                         : 16'(-$urandom_range(32768, 19661)))
                      : 16'($urandom);
      case ($urandom_range(9))
         0: begin
            w.dc_red_level = $urandom; w.dc_ir_level = $urandom;
            w.ac_red_level = $urandom; w.ac_ir_level = $urandom;
         end
         1: begin
            w.dc_red_level = $urandom_range(3); w.dc_ir_level = $urandom;
            w.ac_red_level = $urandom_range(3); w.ac_ir_level = $urandom_range(2);
         end
         default: begin
            base = 24'($urandom_range(24'hFFFFFF, 1000));
            w.dc_red_level = base;
            w.dc_ir_level = 24'($urandom_range(24'hFFFFFF, 1000));
            w.ac_ir_level = 24'(w.dc_ir_level / $urandom_range(200, 20) + 1);
            // ratio roughly 0.3 .. 1.6
            w.ac_red_level = 24'((64'(w.dc_red_level) * w.ac_ir_level / w.dc_ir_level)
                                 * $urandom_range(160, 30) / 100 + 1);
         end
      endcase
      return w;
   endfunction

   function automatic spo2r_pkg::req_type mk(bit p, int qual, int corr, int dr, int di,
                                             int ar, int ai);
      spo2r_pkg::req_type w;
      w.pulse_detected = p; w.quality_level = 16'(qual); w.correlation = 16'(corr);
      w.dc_red_level = 24'(dr); w.dc_ir_level = 24'(di);
      w.ac_red_level = 24'(ar); w.ac_ir_level = 24'(ai);
      return w;
   endfunction

   function automatic spo2r_pkg::rsp_type early(spo2r_pkg::status_type st);
      spo2r_pkg::rsp_type o;
      o = '0; o.status = st;
      return o;
   endfunction

   // result checker
   always @(posedge clock) begin
      spo2r_pkg::rsp_type e;
      cycles <= cycles + 1;
      if (!reset) rsp_stall <= ($urandom_range(99) < recv_idle);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_q.size() == 0) begin
            $display("%0t unexpected transaction %h", $realtime, rsp_data);
            errors++;
         end else begin
            e = expected_q.pop_front();
            if (e !== rsp_data) begin
               $display("%0t mismatch expected %p actual %p", $realtime, e, rsp_data);
               errors++;
            end
         end
      end
      if (cycles >= LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      row_type rw;
      cal_a = spo2r_pkg::COEF_A_RST; cal_b = spo2r_pkg::COEF_B_RST;
      cal_c = spo2r_pkg::COEF_C_RST;
      lim_min = spo2r_pkg::RATIO_MIN_RST; lim_max = spo2r_pkg::RATIO_MAX_RST;
      cal_flag = 1'b0; allow_flag = 1'b1; cal_ver = '0;

      rows.push_back('{mk(0, 65535, 32767, 100, 100, 10, 10), 1,
                       early(spo2r_pkg::ST_NO_SIGNAL)});
      rows.push_back('{mk(1, 32767, 32767, 100, 100, 10, 10), 1,
                       early(spo2r_pkg::ST_LOW_QUALITY)});
      rows.push_back('{mk(1, 65535, 19660, 100, 100, 10, 10), 1,
                       early(spo2r_pkg::ST_LOW_QUALITY)});
      rows.push_back('{mk(1, 65535, -19660, 100, 100, 10, 10), 1,
                       early(spo2r_pkg::ST_LOW_QUALITY)});
      rows.push_back('{mk(1, 65535, -32768, 0, 100, 10, 10), 1,
                       early(spo2r_pkg::ST_NO_SIGNAL)});
      rows.push_back('{mk(1, 65535, 32767, 100, 0, 10, 10), 1,
                       early(spo2r_pkg::ST_NO_SIGNAL)});
      rows.push_back('{mk(1, 65535, 32767, 100, 100, 0, 10), 1,
                       early(spo2r_pkg::ST_NO_SIGNAL)});
      rows.push_back('{mk(1, 65535, 32767, 100, 100, 10, 0), 1,
                       early(spo2r_pkg::ST_NO_SIGNAL)});
      rows.push_back('{mk(1, 65535, 32767, 1, 24'hFFFFFF, 1, 1), 0, '0});
      rows.push_back('{mk(1, 65535, 32767, 1, 100000000 % 16777216, 1, 1), 0, '0});
      rows.push_back('{mk(1, 65535, 32767, 1, 1, 24'hFFFFFF, 24'hFFFFFF), 0, '0});
      rows.push_back('{mk(1, 65535, 32767, 1, 1, 16, 1), 1,
                       early(spo2r_pkg::ST_INTERNAL)});
      rows.push_back('{mk(1, 65535, 32767, 1, 24'hFFFFFF, 24'hFFFFFF, 1), 1,
                       early(spo2r_pkg::ST_INTERNAL)});
      rows.push_back('{mk(1, 32768, 19661, 100, 100, 15, 1), 0, '0});
      rows.push_back('{mk(1, 65535, -32768, 1000, 1000, 50, 100), 0, '0});
      rows.push_back('{mk(1, 65535, 32767, 1000, 1000, 40, 100), 0, '0});
      rows.push_back('{mk(1, 65535, 32767, 1000, 1000, 200, 100), 0, '0});
      rows.push_back('{mk(1, 40000, 25000, 1000, 1000, 1, 5), 0, '0});
      rows.push_back('{mk(1, 65535, 32767, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF),
                       0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i]) send(rows[i].w, rows[i].has_rsp, rows[i].r);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               csr_write(spo2r_pkg::CSR_IS_CAL, 1);
               csr_write(spo2r_pkg::CSR_VERSION, 16'hFFFF);
               csr_write(spo2r_pkg::CSR_COEF_A, 32'hFFF0_0000);
               csr_write(spo2r_pkg::CSR_COEF_B, 32'hFFF6_0000);
               csr_write(spo2r_pkg::CSR_COEF_C, 32'h0070_0000);
            end
            1: begin
               csr_write(spo2r_pkg::CSR_IS_CAL, 0);
               csr_write(spo2r_pkg::CSR_ALLOW_UNCAL, 0);
               csr_write(spo2r_pkg::CSR_VERSION, $urandom);
            end
            2: begin
               csr_write(spo2r_pkg::CSR_ALLOW_UNCAL, 1);
               csr_write(spo2r_pkg::CSR_RATIO_MIN, 0);
               csr_write(spo2r_pkg::CSR_RATIO_MAX, 20'hFFFFF);
               csr_write(spo2r_pkg::CSR_COEF_A, 32'h7FFF_FFFF);
               csr_write(spo2r_pkg::CSR_COEF_B, 32'h8000_0000);
               csr_write(spo2r_pkg::CSR_COEF_C, 32'h0064_8000);
               send_idle = 60; recv_idle = 13;
            end
            3: begin
               csr_write(spo2r_pkg::CSR_RATIO_MIN, 40000);
               csr_write(spo2r_pkg::CSR_RATIO_MAX, 40000);
               csr_write(spo2r_pkg::CSR_COEF_A, 0);
               csr_write(spo2r_pkg::CSR_COEF_B, 32'hFFE7_0000);
               csr_write(spo2r_pkg::CSR_COEF_C, 32'h006E_0000);
               csr_write(spo2r_pkg::CSR_IS_CAL, 1);
            end
            4: begin
               csr_write(spo2r_pkg::CSR_RATIO_MIN, 120000);
               csr_write(spo2r_pkg::CSR_RATIO_MAX, 20000);
               send_idle = 0; recv_idle = 0;
            end
            default: begin
               csr_write(spo2r_pkg::CSR_RATIO_MIN, 13107);
               csr_write(spo2r_pkg::CSR_RATIO_MAX, 131072);
               csr_write(spo2r_pkg::CSR_COEF_A, $urandom_range(200000));
               csr_write(spo2r_pkg::CSR_COEF_B, 32'(-$urandom_range(3000000)));
               csr_write(spo2r_pkg::CSR_COEF_C, $urandom_range(7500000, 6000000));
               csr_write(spo2r_pkg::CSR_VERSION, 0);
            end
         endcase
         for (int n = 0; n < 85; n++) begin
            if (phase == 1 && n == 40) begin
               req_valid <= 1'b0;
               while (expected_q.size() != 0) @(posedge clock);
            end
            send(rand_window());
         end
         drain();
      end

      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
